FILE: design/sle_pkg.sv
// ----------------------------------------------------------------------------
// sle_pkg: shared types and constants of the sorted list engine
// Sizes, action and status codes, the cell command struct and the
// controller states.
// ----------------------------------------------------------------------------
package sle_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = 5;
  localparam int WORD_W = 32;
  localparam int POS_W = 8;
  localparam int ACT_W = 2;
  localparam int STAT_W = 2;

  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_DELETE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_PARTITION = 2'd2;
  localparam logic [ACT_W-1:0] ACT_READ = 2'd3;

  localparam logic [STAT_W-1:0] STAT_DONE = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BADPOS = 2'd2;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_CMP,
    CELL_INS,
    CELL_DEL,
    CELL_SWAP
  } cell_op_t;

  typedef struct packed {
    cell_op_t                  op;
    logic signed [WORD_W-1:0]  x;
    logic [CNT_W-1:0]          cnt;
    logic                      phase;
    logic [IDX_W-1:0]          del_idx;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS,
    ST_DEL,
    ST_PART,
    ST_OUT
  } sle_state_t;

endpackage

FILE: design/sle_in_if.sv
// ----------------------------------------------------------------------------
// sle_in_if: action channel of the sorted list engine
// Valid/ready channel carrying one action beat.
// ----------------------------------------------------------------------------
interface sle_in_if
  import sle_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [ACT_W-1:0]         action;
  logic signed [WORD_W-1:0] value;
  logic [POS_W-1:0]         position;

  modport source (output valid, action, value, position, input ready);
  modport sink (input valid, action, value, position, output ready);
endinterface

FILE: design/sle_out_if.sv
// ----------------------------------------------------------------------------
// sle_out_if: result channel of the sorted list engine
// Valid/ready channel carrying one result beat.
// ----------------------------------------------------------------------------
interface sle_out_if
  import sle_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] read_value;
  logic [CNT_W-1:0]         entry_count;
  logic [STAT_W-1:0]        status;

  modport source (output valid, read_value, entry_count, status, input ready);
  modport sink (input valid, read_value, entry_count, status, output ready);
endinterface

FILE: design/sle_cell.sv
// ----------------------------------------------------------------------------
// sle_cell: one list slot
// Holds one word; compares, shifts right on insert, shifts left on delete
// and swaps with a neighbor during the odd-first partition.
// ----------------------------------------------------------------------------
module sle_cell
  import sle_pkg::*;
(
  input  logic                     clk,
  input  cell_ctl_t                ctl,
  input  logic [IDX_W-1:0]         idx,
  input  logic signed [WORD_W-1:0] left_data,
  input  logic                     left_prefix,
  input  logic signed [WORD_W-1:0] right_data,
  input  logic                     right_valid,
  output logic signed [WORD_W-1:0] data,
  output logic                     valid,
  output logic                     prefix_out
);

  logic signed [WORD_W-1:0] data_r, data_nxt;
  logic                     mark_r, mark_nxt;
  logic                     is_left;
  logic                     swap_left, swap_right;

  assign valid      = ({1'b0, idx} < ctl.cnt);
  assign data       = data_r;
  // the first marked slot takes the new word, every slot after it shifts
  assign prefix_out = left_prefix | mark_r;

  assign is_left    = (idx[0] == ctl.phase);
  // even word ahead of odd word: exchange
  assign swap_left  = is_left & valid & right_valid & ~data_r[0] & right_data[0];
  assign swap_right = ~is_left & valid & ~left_data[0] & data_r[0];

  always_comb begin
    data_nxt = data_r;
    mark_nxt = mark_r;
    unique case (ctl.op)
      CELL_HOLD: ;
      CELL_CMP: mark_nxt = ~valid | (data_r >= ctl.x);
      CELL_INS: begin
        if (left_prefix) begin
          data_nxt = left_data;
        end else if (mark_r) begin
          data_nxt = ctl.x;
        end
      end
      CELL_DEL: begin
        if (idx >= ctl.del_idx) begin
          data_nxt = right_data;
        end
      end
      CELL_SWAP: begin
        if (swap_left) begin
          data_nxt = right_data;
        end else if (swap_right) begin
          data_nxt = left_data;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    mark_r <= mark_nxt;
  end

endmodule

FILE: design/sorted_list_engine.sv
// ----------------------------------------------------------------------------
// sorted_list_engine: ordered list of signed words in a chain of cells
// Sorted insert, delete and read at a 1-based position, and a stable
// odd-first partition, over a row of DEPTH slot cells.
// ----------------------------------------------------------------------------
//  channel | direction | beat contents
//  --------+-----------+-------------------------------------------
//  in_ch   | in        | action, value, position
//  out_ch  | out       | read_value, entry_count, status
//
// Steps: a read or a rejected action goes from the accept cycle straight to
// the result load in ST_OUT; an insert compares on the accept edge and then
// takes one shift step in ST_INS, a delete takes one shift step in ST_DEL;
// partition runs its transposition phases in ST_PART, one per cycle, then
// loads the result. The cell row works on one action at a time.
// Reset clears the count, the controller and the result valid flag only; slot
// contents need no clearing because only slots below the count are ever read.
// Stalls: the result register holds a beat while out_ch.ready is low; the
// next action is accepted meanwhile and its result waits in the controller,
// which accepts nothing more until that result moves into the register.
// ----------------------------------------------------------------------------
module sorted_list_engine
  import sle_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  sle_in_if.sink      in_ch,
  sle_out_if.source   out_ch
);

  sle_state_t state_r, state_nxt;

  logic [CNT_W-1:0]         count_r;
  logic signed [WORD_W-1:0] value_r;
  logic [IDX_W-1:0]         del_idx_r;
  logic [IDX_W-1:0]         ph_r;
  logic signed [WORD_W-1:0] res_rd_r, res_rd_nxt;
  logic [STAT_W-1:0]        res_st_r, res_st_nxt;

  logic                     out_valid_r;
  logic signed [WORD_W-1:0] out_rd_r;
  logic [CNT_W-1:0]         out_cnt_r;
  logic [STAT_W-1:0]        out_st_r;

  logic                     accept;
  logic                     full;
  logic                     bad_pos;
  logic                     out_load;
  logic [IDX_W-1:0]         in_idx;
  cell_ctl_t                ctl;

  logic signed [WORD_W-1:0] cell_data   [DEPTH];
  logic                     cell_valid  [DEPTH];
  logic                     cell_prefix [DEPTH];

  assign accept  = in_ch.valid & in_ch.ready;
  assign full    = (count_r == CNT_W'(DEPTH));
  assign bad_pos = (in_ch.position == '0) ||
                   (in_ch.position > POS_W'(count_r));
  // only used when the position is in range, so the low bits suffice
  assign in_idx  = IDX_W'(in_ch.position - POS_W'(1));

  // --------------------------------------------------------------------------
  // Cell row: left neighbor feeds inserts, right neighbor feeds deletes
  // --------------------------------------------------------------------------
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [WORD_W-1:0] l_data;
    logic                     l_prefix;
    logic signed [WORD_W-1:0] r_data;
    logic                     r_valid;

    if (i == 0) begin : g_head
      // odd boundary word: the head slot never swaps leftward
      assign l_data   = WORD_W'(1);
      assign l_prefix = 1'b0;
    end else begin : g_mid
      assign l_data   = cell_data[i-1];
      assign l_prefix = cell_prefix[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign r_data  = '0;
      assign r_valid = 1'b0;
    end else begin : g_body
      assign r_data  = cell_data[i+1];
      assign r_valid = cell_valid[i+1];
    end

    sle_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .idx         (IDX_W'(i)),
      .left_data   (l_data),
      .left_prefix (l_prefix),
      .right_data  (r_data),
      .right_valid (r_valid),
      .data        (cell_data[i]),
      .valid       (cell_valid[i]),
      .prefix_out  (cell_prefix[i])
    );
  end

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_ch.action)
            ACT_INSERT:    state_nxt = full ? ST_OUT : ST_INS;
            ACT_DELETE:    state_nxt = bad_pos ? ST_OUT : ST_DEL;
            ACT_PARTITION: state_nxt = ST_PART;
            ACT_READ:      state_nxt = ST_OUT;
            default:       state_nxt = ST_OUT;
          endcase
        end
      end
      ST_INS:  state_nxt = ST_OUT;
      ST_DEL:  state_nxt = ST_OUT;
      ST_PART: begin
        if (ph_r == IDX_W'(DEPTH - 1)) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Outputs of the controller: cell command, ready, result load
  // --------------------------------------------------------------------------
  always_comb begin
    ctl.op      = CELL_HOLD;
    ctl.x       = value_r;
    ctl.cnt     = count_r;
    ctl.phase   = ph_r[0];
    ctl.del_idx = del_idx_r;
    in_ch.ready = 1'b0;
    out_load    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        // compare the new word against every slot on the accept edge
        ctl.x = in_ch.value;
        if (accept && in_ch.action == ACT_INSERT && !full) begin
          ctl.op = CELL_CMP;
        end
      end
      ST_INS:  ctl.op = CELL_INS;
      ST_DEL:  ctl.op = CELL_DEL;
      ST_PART: ctl.op = CELL_SWAP;
      ST_OUT:  out_load = !out_valid_r || out_ch.ready;
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Result of the incoming action: status and read data
  // --------------------------------------------------------------------------
  always_comb begin
    res_rd_nxt = '0;
    res_st_nxt = STAT_DONE;
    unique case (in_ch.action)
      ACT_INSERT: begin
        if (full) begin
          res_st_nxt = STAT_FULL;
        end
      end
      ACT_DELETE: begin
        if (bad_pos) begin
          res_st_nxt = STAT_BADPOS;
        end
      end
      ACT_PARTITION: ;
      ACT_READ: begin
        if (bad_pos) begin
          res_st_nxt = STAT_BADPOS;
        end else begin
          res_rd_nxt = cell_data[in_idx];
        end
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_INS) begin
        count_r <= count_r + CNT_W'(1);
      end else if (state_r == ST_DEL) begin
        count_r <= count_r - CNT_W'(1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      value_r   <= in_ch.value;
      del_idx_r <= in_idx;
      res_rd_r  <= res_rd_nxt;
      res_st_r  <= res_st_nxt;
    end
    // advance the transposition phase; restart on every accept
    if (accept) begin
      ph_r <= '0;
    end else if (state_r == ST_PART) begin
      ph_r <= ph_r + IDX_W'(1);
    end
    if (out_load) begin
      out_rd_r  <= res_rd_r;
      out_cnt_r <= count_r;
      out_st_r  <= res_st_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.read_value  = out_rd_r;
  assign out_ch.entry_count = out_cnt_r;
  assign out_ch.status      = out_st_r;

endmodule

FILE: design/sle_checker.sv
// ----------------------------------------------------------------------------
// sle_checker: port-level checks of the sorted list engine
// Watches the result channel and binds to the top level.
// ----------------------------------------------------------------------------
module sle_checker
  import sle_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [WORD_W-1:0] read_value,
  input logic [CNT_W-1:0]         entry_count,
  input logic [STAT_W-1:0]        status
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(read_value) &&
      $stable(entry_count) && $stable(status))
    else $error("result beat changed while stalled");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> entry_count <= CNT_W'(DEPTH))
    else $error("entry count beyond depth");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == STAT_FULL |-> entry_count == CNT_W'(DEPTH))
    else $error("full status with room left");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != STAT_DONE |-> read_value == '0)
    else $error("rejected action returned data");

endmodule

bind sorted_list_engine sle_checker u_sle_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .read_value  (out_ch.read_value),
  .entry_count (out_ch.entry_count),
  .status      (out_ch.status)
);

FILE: bench/sorted_list_engine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_engine_tb: self-checking bench for the sorted list engine
// Drives insert, delete, partition and read beats through the action channel,
// keeps a shadow copy of the list, and checks every result beat against it
// under several sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module sorted_list_engine_tb;
  import sle_pkg::*;

  localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
  localparam int RANDOM_PER_PHASE = 190;
  localparam int NUM_PHASES = 4;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int MAX_REPORTED = 10;
  // Worst case is far below this: a partition per beat, both sides idling.
  localparam longint RUN_LIMIT_NS = 64'd3_000_000;

  // One result beat as the list should produce it.
  typedef struct {
    logic signed [WORD_W-1:0] read_value;
    logic [CNT_W-1:0]         entry_count;
    logic [STAT_W-1:0]        status;
  } list_result_t;

  // Shadow of the list: applies each accepted action and queues its result.
  class list_shadow;
    logic signed [WORD_W-1:0] slots [DEPTH];
    int                       used;
    list_result_t             pending_results [$];
    int                       mismatches;

    function new();
      used = 0;
      mismatches = 0;
      foreach (slots[i]) slots[i] = '0;
    endfunction

    function void apply_action(input logic [ACT_W-1:0] act,
                               input logic signed [WORD_W-1:0] val,
                               input logic [POS_W-1:0] pos);
      list_result_t             res;
      logic signed [WORD_W-1:0] regrouped [DEPTH];
      int                       slot;
      int                       n;
      res.read_value = '0;
      res.status = STAT_DONE;
      case (act)
        ACT_INSERT: begin
          if (used >= DEPTH) begin
            res.status = STAT_FULL;
          end else begin
            slot = 0;
            if (used != 0 && slots[0] < val) begin
              slot = 1;
              while (slot < used && slots[slot] < val) slot++;
            end
            for (int i = used; i > slot; i--) slots[i] = slots[i-1];
            slots[slot] = val;
            used++;
          end
        end
        ACT_DELETE: begin
          if (pos == 0 || pos > used) begin
            res.status = STAT_BADPOS;
          end else begin
            for (int i = pos - 1; i + 1 < used; i++) slots[i] = slots[i+1];
            used--;
          end
        end
        ACT_PARTITION: begin
          // odd words first, then even, order kept inside each group
          n = 0;
          for (int i = 0; i < used; i++)
            if (slots[i][0]) regrouped[n++] = slots[i];
          for (int i = 0; i < used; i++)
            if (!slots[i][0]) regrouped[n++] = slots[i];
          for (int i = 0; i < used; i++) slots[i] = regrouped[i];
        end
        default: begin
          if (pos == 0 || pos > used) res.status = STAT_BADPOS;
          else res.read_value = slots[pos-1];
        end
      endcase
      res.entry_count = CNT_W'(used);
      pending_results.push_back(res);
    endfunction

    function void compare_result(input logic signed [WORD_W-1:0] rv,
                                 input logic [CNT_W-1:0] cnt,
                                 input logic [STAT_W-1:0] st);
      list_result_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTED)
          $display("%0t: unexpected result beat value=%0d count=%0d status=%0d",
                   $realtime, rv, cnt, st);
        return;
      end
      want = pending_results.pop_front();
      if (rv !== want.read_value || cnt !== want.entry_count || st !== want.status) begin
        mismatches++;
        if (mismatches <= MAX_REPORTED)
          $display("%0t: mismatch expected value=%0d count=%0d status=%0d, %s",
                   $realtime, want.read_value, want.entry_count, want.status,
                   $sformatf("got value=%0d count=%0d status=%0d", rv, cnt, st));
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  sle_in_if  in_ch ();
  sle_out_if out_ch ();

  sorted_list_engine u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  list_shadow shadow = new();

  // Idling knobs, set per phase by the main sequence.
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  // Cycles of forced back-pressure; counted down by the receiver process.
  int hold_off_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(RUN_LIMIT_NS);
    $display("TB_ERROR");
    $finish;
  end

  // Result side: sample the beat at the rising edge, update ready at the
  // falling edge. A pending hold-off wins over the random stall choice.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        shadow.compare_result(out_ch.read_value, out_ch.entry_count, out_ch.status);
      @(negedge clk);
      if (hold_off_cycles > 0) begin
        out_ch.ready = 1'b0;
        hold_off_cycles--;
      end else begin
        out_ch.ready = ($urandom_range(0, 99) >= receiver_stall_pct);
      end
    end
  end

  // Offer one action beat, with optional idle cycles first, and return at the
  // rising edge where it is accepted. Valid stays high into the next beat if
  // no gap follows, so it is never lowered and raised in the same step.
  task automatic send_beat(input logic [ACT_W-1:0] act,
                           input logic signed [WORD_W-1:0] val,
                           input logic [POS_W-1:0] pos);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.action = act;
    in_ch.value = val;
    in_ch.position = pos;
    do @(posedge clk); while (!in_ch.ready);
    shadow.apply_action(act, val, pos);
  endtask

  // Drop valid and hold off until every queued result has come back.
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (shadow.pending_results.size() != 0) @(posedge clk);
  endtask

  // Mix of wide random words, small clustered ones (many ties), the extremes
  // and copies of words already in the list.
  function automatic logic signed [WORD_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5:       return $signed($urandom_range(0, 40)) - 20;
      6: begin
        case ($urandom_range(0, 3))
          0:       return WORD_MIN;
          1:       return WORD_MAX;
          2:       return '0;
          default: return -1;
        endcase
      end
      default: begin
        if (shadow.used > 0) return shadow.slots[$urandom_range(0, shadow.used - 1)];
        return $urandom;
      end
    endcase
  endfunction

  // One random beat. Positions mostly land in or just past the list so that
  // delete and read do real work; the rest covers the whole position range.
  task automatic send_random_item(input int insert_pct);
    logic [ACT_W-1:0] act;
    logic [POS_W-1:0] pos;
    int               r;
    r = $urandom_range(0, 99);
    if (r < insert_pct) begin
      act = ACT_INSERT;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 40) act = ACT_DELETE;
      else if (r < 85) act = ACT_READ;
      else act = ACT_PARTITION;
    end
    if ($urandom_range(0, 4) == 0) pos = POS_W'($urandom_range(0, 255));
    else pos = POS_W'($urandom_range(0, shadow.used + 1));
    send_beat(act, pick_value(), pos);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.action = ACT_INSERT;
    in_ch.value = '0;
    in_ch.position = '0;
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty list cases, extremes, odd negatives, ties, bad positions.
    send_beat(ACT_READ, '0, 8'd1);
    send_beat(ACT_DELETE, '0, 8'd1);
    send_beat(ACT_PARTITION, '0, 8'd0);
    send_beat(ACT_INSERT, '0, 8'd0);
    send_beat(ACT_INSERT, WORD_MAX, 8'd0);
    send_beat(ACT_INSERT, WORD_MIN, 8'd0);
    send_beat(ACT_INSERT, -1, 8'd0);
    send_beat(ACT_INSERT, 1, 8'd0);
    send_beat(ACT_INSERT, -3, 8'd0);
    send_beat(ACT_INSERT, 1, 8'hFF);
    send_beat(ACT_INSERT, 6, 8'd0);
    send_beat(ACT_PARTITION, '1, 8'hFF);
    send_beat(ACT_READ, '0, 8'd1);
    send_beat(ACT_READ, '0, 8'd8);
    send_beat(ACT_READ, '0, 8'd9);
    send_beat(ACT_READ, '0, 8'd0);
    send_beat(ACT_READ, '0, 8'd255);
    send_beat(ACT_DELETE, '0, 8'd0);
    send_beat(ACT_DELETE, '0, 8'd255);
    send_beat(ACT_DELETE, '0, 8'd8);
    send_beat(ACT_DELETE, '0, 8'd1);
    send_beat(ACT_READ, '0, 8'd1);
    drain_results();

    // Random phases: none idle, sender idle, receiver stalls, both.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 0;
          // Hold the result side off while beats keep coming: fills the
          // block and stalls its input.
          hold_off_cycles = LONG_HOLD_CYCLES;
        end
        1: begin
          sender_idle_pct = 57;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 57;
        end
        default: begin
          sender_idle_pct = 34;
          receiver_stall_pct = 34;
        end
      endcase
      // Alternate fill-heavy and drain-heavy stretches so the list swings
      // between full and empty.
      for (int n = 0; n < RANDOM_PER_PHASE; n++)
        send_random_item(((n / 40) % 2) ? 15 : 70);
      drain_results();
    end

    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    drain_results();
    repeat (4 * DEPTH) @(posedge clk);
    if (shadow.mismatches == 0 && shadow.pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
design/sle_pkg.sv
design/sle_in_if.sv
design/sle_out_if.sv
design/sle_cell.sv
design/sorted_list_engine.sv
design/sle_checker.sv
bench/sorted_list_engine_tb.sv
